// File: hw/rtl/chained_hash_table_engine_macros.svh
// assertion helpers shared by the hash table rtl
`ifndef CHAINED_HASH_TABLE_ENGINE_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_MACROS_SVH

// same-cycle implication
`define CHT_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CHT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/cht_pkg.sv
package cht_pkg;

   localparam int KEY_W      = 32;
   localparam int DATA_W     = 32;
   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 9;
   localparam int DIGIT_BITS = 4;
   localparam int HASH_STEPS = KEY_W / DIGIT_BITS;
   localparam int STEP_W     = $clog2(HASH_STEPS);

   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_INVALID = 3'd1,
      ST_FULL    = 3'd2,
      ST_DUP     = 3'd3,
      ST_MISSING = 3'd4
   } status_type;

   typedef struct packed {
      logic       load;
      logic       rem_step;
      logic       head_read;
      logic       walk_init;
      logic       node_read;
      logic       advance;
      logic       hit;
      logic       free_read;
      logic       insert;
      logic       unlink;
      logic       free_node;
      logic       clear;
      logic       res_load;
      logic       res_found;
      status_type res_status;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic rem_last;
      logic key_bad;
      logic is_insert;
      logic is_delete;
      logic full;
      logic walk_end;
      logic key_match;
   } sts_type;

endpackage

// File: hw/rtl/cht_ctrl.sv
module cht_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  cht_pkg::sts_type sts,
   output cht_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_HASH,
      S_HEAD_RD,
      S_HEAD,
      S_NODE_RD,
      S_NODE_CK,
      S_ALLOC,
      S_INSERT,
      S_UNLINK,
      S_FREE,
      S_FINISH
   } state_type;

   state_type           state_ff, state_in;
   cht_pkg::status_type code_ff, code_in;
   logic                found_ff, found_in;
   logic                rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.res_status = code_ff;
      state_in       = state_ff;
      code_in        = code_ff;
      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               found_in = 1'b0;
               state_in = S_START;
            end
         end
         S_START: begin
            priority if (sts.key_bad) begin
               code_in  = sts.is_insert ? cht_pkg::ST_INVALID : cht_pkg::ST_MISSING;
               state_in = S_FINISH;
            end else if (sts.is_insert && sts.full) begin
               code_in  = cht_pkg::ST_FULL;
               state_in = S_FINISH;
            end else begin
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            cmd.rem_step = 1'b1;
            if (sts.rem_last) state_in = S_HEAD_RD;
         end
         S_HEAD_RD: begin
            cmd.head_read = 1'b1;
            state_in      = S_HEAD;
         end
         S_HEAD: begin
            cmd.walk_init = 1'b1;
            state_in      = S_NODE_RD;
         end
         S_NODE_RD: begin
            if (sts.walk_end) begin
               if (sts.is_insert) begin
                  state_in = S_ALLOC;
               end else begin
                  code_in  = cht_pkg::ST_MISSING;
                  state_in = S_FINISH;
               end
            end else begin
               cmd.node_read = 1'b1;
               state_in      = S_NODE_CK;
            end
         end
         S_NODE_CK: begin
            if (sts.key_match) begin
               cmd.hit = 1'b1;
               priority if (sts.is_insert) begin
                  code_in  = cht_pkg::ST_DUP;
                  state_in = S_FINISH;
               end else if (sts.is_delete) begin
                  state_in = S_UNLINK;
               end else begin
                  code_in  = cht_pkg::ST_OK;
                  found_in = 1'b1;
                  state_in = S_FINISH;
               end
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_NODE_RD;
            end
         end
         S_ALLOC: begin
            cmd.free_read = 1'b1;
            state_in      = S_INSERT;
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            code_in    = cht_pkg::ST_OK;
            state_in   = S_FINISH;
         end
         S_UNLINK: begin
            cmd.unlink = 1'b1;
            state_in   = S_FREE;
         end
         S_FREE: begin
            cmd.free_node = 1'b1;
            code_in       = cht_pkg::ST_OK;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            // wait until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.res_load  = 1'b1;
               cmd.res_found = found_ff;
               rsp_valid_in  = 1'b1;
               found_in      = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         code_ff      <= cht_pkg::ST_OK;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/cht_dp.sv
`include "chained_hash_table_engine_macros.svh"

module cht_dp #(
   parameter int BUCKETS  = 64,
   parameter int CAPACITY = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  cht_pkg::cmd_type                cmd,
   output cht_pkg::sts_type                sts,
   input  logic [cht_pkg::MODE_W-1:0]      req_mode,
   input  logic [cht_pkg::KEY_W-1:0]       req_key,
   input  logic [cht_pkg::DATA_W-1:0]      req_payload,
   output logic [cht_pkg::STATUS_W-1:0]    rsp_status,
   output logic [cht_pkg::DATA_W-1:0]      rsp_found_data,
   output logic [cht_pkg::COUNT_W-1:0]     rsp_entry_count
);

   localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int RW   = BW + 1;
   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int NW   = $clog2(CAPACITY + 1);
   localparam int MAXD = (BUCKETS > CAPACITY) ? BUCKETS : CAPACITY;
   localparam int SW   = $clog2(MAXD + 1);
   localparam logic [NW-1:0] NIL = NW'(CAPACITY);

   localparam int KW = cht_pkg::KEY_W;
   localparam int DW = cht_pkg::DATA_W;

   // node and bucket stores
   logic [NW-1:0] bucket_head_mem [BUCKETS];
   logic [KW-1:0] node_key_mem    [CAPACITY];
   logic [DW-1:0] node_data_mem   [CAPACITY];
   logic [NW-1:0] node_link_mem   [CAPACITY];

   logic [NW-1:0] head_rd_ff;
   logic [KW-1:0] key_rd_ff;
   logic [DW-1:0] data_rd_ff;
   logic [NW-1:0] link_rd_ff;

   logic [cht_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [KW-1:0]              key_ff, key_in;
   logic [DW-1:0]              data_ff, data_in;
   logic [KW-1:0]              kshift_ff, kshift_in;
   logic [RW-1:0]              rem_ff, rem_in;
   logic [cht_pkg::STEP_W-1:0] step_ff, step_in;
   logic [NW-1:0]              cur_ff, cur_in;
   logic [NW-1:0]              prev_ff, prev_in;
   logic [NW-1:0]              hitlink_ff, hitlink_in;
   logic [NW-1:0]              steps_ff, steps_in;
   logic [NW-1:0]              free_ff, free_in;
   logic [NW-1:0]              count_ff, count_in;
   logic [SW-1:0]              sweep_ff, sweep_in;
   logic [cht_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [DW-1:0]              found_ff, found_in;
   logic [cht_pkg::COUNT_W-1:0] entry_ff, entry_in;

   logic [BW-1:0] bucket;
   logic          head_we;
   logic [BW-1:0] head_waddr;
   logic [NW-1:0] head_wdata;
   logic          link_we;
   logic [AW-1:0] link_waddr;
   logic [NW-1:0] link_wdata;
   logic [AW-1:0] link_raddr;

   assign bucket = rem_ff[BW-1:0];

   // status back to the controller
   always_comb begin
      sts.clear_last = (sweep_ff == SW'(MAXD - 1));
      sts.rem_last   = (step_ff == cht_pkg::STEP_W'(cht_pkg::HASH_STEPS - 1));
      sts.key_bad    = (key_ff == '0) || key_ff[KW-1];
      sts.is_insert  = (mode_ff == cht_pkg::MODE_INSERT);
      sts.is_delete  = (mode_ff == cht_pkg::MODE_DELETE);
      sts.full       = (count_ff >= NIL) || (free_ff >= NIL);
      sts.walk_end   = (cur_ff >= NIL) || (steps_ff >= NIL);
      sts.key_match  = (key_rd_ff == key_ff);
   end

   // bucket remainder, four key bits per step, msb first
   always_comb begin
      logic [RW-1:0] r;
      logic [KW-1:0] ks;
      r  = rem_ff;
      ks = kshift_ff;
      for (int i = 0; i < cht_pkg::DIGIT_BITS; i++) begin
         r  = {r[RW-2:0], ks[KW-1]};
         ks = {ks[KW-2:0], 1'b0};
         if (r >= RW'(BUCKETS)) r = r - RW'(BUCKETS);
      end
      rem_in    = rem_ff;
      kshift_in = kshift_ff;
      step_in   = step_ff;
      if (cmd.load) begin
         rem_in    = '0;
         kshift_in = req_key;
         step_in   = '0;
      end else if (cmd.rem_step) begin
         rem_in    = r;
         kshift_in = ks;
         step_in   = step_ff + cht_pkg::STEP_W'(1);
      end
   end

   always_comb begin
      mode_in    = cmd.load ? req_mode    : mode_ff;
      key_in     = cmd.load ? req_key     : key_ff;
      data_in    = cmd.load ? req_payload : data_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      steps_in   = steps_ff;
      hitlink_in = cmd.hit ? link_rd_ff : hitlink_ff;
      free_in    = free_ff;
      count_in   = count_ff;
      sweep_in   = cmd.clear ? sweep_ff + SW'(1) : sweep_ff;
      if (cmd.walk_init) begin
         cur_in   = head_rd_ff;
         prev_in  = NIL;
         steps_in = '0;
      end else if (cmd.advance) begin
         cur_in   = link_rd_ff;
         prev_in  = cur_ff;
         steps_in = steps_ff + NW'(1);
      end
      if (cmd.insert) begin
         free_in  = link_rd_ff;
         count_in = count_ff + NW'(1);
      end else if (cmd.free_node) begin
         free_in = cur_ff;
         if (count_ff != '0) count_in = count_ff - NW'(1);
      end
      status_in = cmd.res_load ? cmd.res_status : status_ff;
      found_in  = found_ff;
      entry_in  = entry_ff;
      if (cmd.res_load) begin
         found_in = cmd.res_found ? data_rd_ff : '0;
         entry_in = cht_pkg::COUNT_W'(count_ff);
      end
   end

   // write port selection
   always_comb begin
      head_we    = 1'b0;
      head_waddr = bucket;
      head_wdata = free_ff;
      priority if (cmd.clear) begin
         head_we    = (sweep_ff < SW'(BUCKETS));
         head_waddr = sweep_ff[BW-1:0];
         head_wdata = NIL;
      end else if (cmd.insert) begin
         head_we = 1'b1;
      end else if (cmd.unlink && (prev_ff >= NIL)) begin
         head_we    = 1'b1;
         head_wdata = hitlink_ff;
      end
   end

   always_comb begin
      link_we    = 1'b0;
      link_waddr = free_ff[AW-1:0];
      link_wdata = head_rd_ff;
      priority if (cmd.clear) begin
         // free list starts as node i pointing at node i+1
         link_we    = (sweep_ff < SW'(CAPACITY));
         link_waddr = sweep_ff[AW-1:0];
         link_wdata = NW'(sweep_ff) + NW'(1);
      end else if (cmd.insert) begin
         link_we = 1'b1;
      end else if (cmd.unlink && (prev_ff < NIL)) begin
         link_we    = 1'b1;
         link_waddr = prev_ff[AW-1:0];
         link_wdata = hitlink_ff;
      end else if (cmd.free_node) begin
         link_we    = 1'b1;
         link_waddr = cur_ff[AW-1:0];
         link_wdata = free_ff;
      end
      link_raddr = cmd.free_read ? free_ff[AW-1:0] : cur_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (head_we) bucket_head_mem[head_waddr] <= head_wdata;
      if (cmd.head_read) head_rd_ff <= bucket_head_mem[bucket];
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         node_key_mem[free_ff[AW-1:0]]  <= key_ff;
         node_data_mem[free_ff[AW-1:0]] <= data_ff;
      end
      if (cmd.node_read) begin
         key_rd_ff  <= node_key_mem[cur_ff[AW-1:0]];
         data_rd_ff <= node_data_mem[cur_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) node_link_mem[link_waddr] <= link_wdata;
      if (cmd.node_read || cmd.free_read) link_rd_ff <= node_link_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff  <= '0;
         count_ff <= '0;
         sweep_ff <= '0;
      end else begin
         free_ff  <= free_in;
         count_ff <= count_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      key_ff     <= key_in;
      data_ff    <= data_in;
      kshift_ff  <= kshift_in;
      rem_ff     <= rem_in;
      step_ff    <= step_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      steps_ff   <= steps_in;
      hitlink_ff <= hitlink_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
      entry_ff   <= entry_in;
   end

   assign rsp_status      = status_ff;
   assign rsp_found_data  = found_ff;
   assign rsp_entry_count = entry_ff;

   `CHT_ASSERT_NOW(a_pool_empty_full, clock, reset, free_ff >= NIL, count_ff == NIL, "free list empty while table not full")
   `CHT_ASSERT_NOW(a_full_pool_empty, clock, reset, count_ff == NIL, free_ff >= NIL, "table full while free list not empty")
   `CHT_ASSERT_NOW(a_insert_has_node, clock, reset, cmd.insert, free_ff < NIL, "insert without a free node")
   `CHT_ASSERT_NEXT(a_insert_count, clock, reset, cmd.insert, count_ff == $past(count_ff) + NW'(1), "insert did not raise the count")

endmodule

// File: hw/rtl/chained_hash_table_engine.sv
// channel  dir  handshake             fields
// req      in   req_valid/req_ready   req_mode, req_key, req_payload
// rsp      out  rsp_valid/rsp_ready   rsp_status, rsp_found_data, rsp_entry_count
//
// one request at a time; the result waits on the 8-step bucket remainder and on the registered
// node reads of each chain node compared
// a rejected key or a full table skips the remainder and chain walk and goes to the result
// after reset a clearing pass sweeps indices up to max(BUCKETS, CAPACITY)-1, empties the
// buckets and links the free list; req_ready stays low until it ends
// the next request is taken while a result still waits; it then stalls until that one leaves
`include "chained_hash_table_engine_macros.svh"

module chained_hash_table_engine #(
   parameter int BUCKETS  = 64,
   parameter int CAPACITY = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_key,
   input  logic [31:0]        req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [31:0]        rsp_found_data,
   output logic [8:0]         rsp_entry_count
);

   cht_pkg::cmd_type cmd;
   cht_pkg::sts_type sts;

   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cht_dp #(
      .BUCKETS  (BUCKETS),
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_mode        (req_mode),
      .req_key         (req_key),
      .req_payload     (req_payload),
      .rsp_status      (rsp_status),
      .rsp_found_data  (rsp_found_data),
      .rsp_entry_count (rsp_entry_count)
   );

   `CHT_ASSERT_NOW(a_found_only_ok, clock, reset, rsp_valid && (rsp_status != cht_pkg::ST_OK), rsp_found_data == '0, "found data on a failed request")

endmodule
